[design/selt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// selt_pkg
// shared types and constants for the shared/exclusive lock table
// ---------------------------------------------------------------------------
package selt_pkg;
   localparam int NumLocksDef = 64;
   localparam int NumProcsDef = 32;
   localparam int LockW = 6;
   localparam int ProcW = 5;
   localparam int CountW = 6;
   localparam int StatusW = 3;

   localparam logic [CountW-1:0] SharedMax = 6'd63;

   localparam logic CmdAcquire = 1'b0;
   localparam logic CmdRelease = 1'b1;

   localparam logic [StatusW-1:0] StGranted  = 3'd0;
   localparam logic [StatusW-1:0] StQueued   = 3'd1;
   localparam logic [StatusW-1:0] StWoken    = 3'd2;
   localparam logic [StatusW-1:0] StReleased = 3'd3;
   localparam logic [StatusW-1:0] StNotHeld  = 3'd4;

   typedef struct packed {
      logic             cmd;
      logic [LockW-1:0] lock_id;
      logic [ProcW-1:0] requester;
      logic             want_exclusive;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [ProcW-1:0]   woken_proc;
      logic               last;
   } rsp_type;
endpackage
`default_nettype wire

[design/selt_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// selt_req_if
// request channel: valid, ready and one request item
// ---------------------------------------------------------------------------
interface selt_req_if;
   logic                valid;
   logic                ready;
   selt_pkg::req_type   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/selt_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// selt_rsp_if
// response channel: valid, ready and one response item
// ---------------------------------------------------------------------------
interface selt_rsp_if;
   logic                valid;
   logic                ready;
   selt_pkg::rsp_type   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/shared_exclusive_lock_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shared_exclusive_lock_table
// reader-writer lock table with per-lock fifo wait queues
// ---------------------------------------------------------------------------
//  channel   dir  contents
//  req_      in   cmd, lock_id, requester, want_exclusive
//  rsp_      out  status, woken_proc, last
//
//  acquire and release items pass through lock memory read, decide with
//  write back, then one response.
//  a release that wakes waiters gives one response per woken process, then writes back.
//  reset clears the lock table one entry at a time before the first item.
//  a stalled response holds the sequencer until it is taken.
module shared_exclusive_lock_table #(
   parameter int NUM_LOCKS = selt_pkg::NumLocksDef,
   parameter int NUM_PROCS = selt_pkg::NumProcsDef
) (
   input  wire logic   clock,
   input  wire logic   reset,
   selt_req_if.sink    req,
   selt_rsp_if.source  rsp
);
   localparam int LIdxW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int PIdxW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int CntW  = $clog2(NUM_PROCS + 1);
   localparam int EntW  = 1 + selt_pkg::CountW + 1 + 2 * PIdxW;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;
   localparam logic [2:0] S_WAKE  = 3'd5;
   localparam logic [2:0] S_WRITE = 3'd6;

   typedef struct packed {
      logic                        excl;
      logic [selt_pkg::CountW-1:0] cnt;
      logic                        nonempty;
      logic [PIdxW-1:0]            head;
      logic [PIdxW-1:0]            tail;
   } entry_type;

   entry_type        lock_mem [NUM_LOCKS];
   logic [PIdxW-1:0] next_mem [NUM_PROCS];
   logic             wex_mem  [NUM_PROCS];
   logic [NUM_PROCS-1:0] next_valid_ff, next_valid_in;

   logic [2:0]       state_ff, state_in;
   logic [LIdxW-1:0] clr_ff, clr_in;
   logic [LIdxW-1:0] lk_ff, lk_in;
   logic [PIdxW-1:0] rq_ff, rq_in;
   logic             cmd_ff, cmd_in, ex_ff, ex_in;
   entry_type        ent_ff, ent_in, rd_ff;
   logic [PIdxW-1:0] p_ff, p_in;
   logic [CntW-1:0]  n_ff, n_in;
   logic             run_ff, run_in;
   selt_pkg::rsp_type out_ff, out_in;
   logic             ovalid_ff, ovalid_in;

   logic             mem_we;
   logic [LIdxW-1:0] mem_wa;
   entry_type        mem_wd;
   logic             nx_we;
   logic [PIdxW-1:0] nx_wa, nx_wd;
   logic             wx_we, wx_wd;
   logic [PIdxW-1:0] nx_p, wx_p_idx;
   logic             has_next, nx_excl, more;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (mem_we) lock_mem[mem_wa] <= mem_wd;
      rd_ff <= lock_mem[lk_in];
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (wx_we) wex_mem[rq_ff] <= wx_wd;
   end

   assign nx_p     = next_mem[p_ff];
   assign wx_p_idx = nx_p;
   assign has_next = next_valid_ff[p_ff];
   assign nx_excl  = wex_mem[wx_p_idx];
   assign more     = run_ff && has_next && !nx_excl && (32'(n_ff) + 1 < NUM_PROCS);

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; lk_in = lk_ff; rq_in = rq_ff;
      cmd_in = cmd_ff; ex_in = ex_ff; ent_in = ent_ff; p_in = p_ff; n_in = n_ff;
      run_in = run_ff; out_in = out_ff; next_valid_in = next_valid_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      mem_we = 1'b0; mem_wa = lk_ff; mem_wd = ent_ff;
      nx_we = 1'b0; wx_we = 1'b0; nx_wa = rq_ff; nx_wd = rq_ff; wx_wd = ex_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1; mem_wa = clr_ff; mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == NUM_LOCKS - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.data.cmd;
               lk_in  = LIdxW'(32'(req.data.lock_id) % NUM_LOCKS);
               rq_in  = PIdxW'(32'(req.data.requester) % NUM_PROCS);
               ex_in  = req.data.want_exclusive;
               state_in = S_READ;
            end
         end
         S_READ: begin
            ent_in = rd_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            out_in = '{status: selt_pkg::StGranted, woken_proc: '0, last: 1'b1};
            state_in = S_WRITE;
            if (cmd_ff == selt_pkg::CmdAcquire) begin
               if (ex_ff && !ent_ff.excl && ent_ff.cnt == '0) begin
                  ent_in.excl = 1'b1;
               end else if (!ex_ff && !ent_ff.excl) begin
                  if (ent_ff.cnt != selt_pkg::SharedMax) ent_in.cnt = ent_ff.cnt + 1'b1;
               end else begin
                  out_in.status = selt_pkg::StQueued;
                  wx_we = 1'b1;
                  next_valid_in[rq_ff] = 1'b0;
                  if (ent_ff.nonempty) begin
                     nx_we = 1'b1; nx_wa = ent_ff.tail;
                     next_valid_in[ent_ff.tail] = 1'b1;
                  end else begin
                     ent_in.head = rq_ff;
                     ent_in.nonempty = 1'b1;
                  end
                  ent_in.tail = rq_ff;
               end
            end else begin
               if (ent_ff.excl || ent_ff.cnt != '0) begin
                  if (ent_ff.excl) ent_in.excl = 1'b0;
                  else ent_in.cnt = ent_ff.cnt - 1'b1;
                  if (ent_ff.nonempty && (ent_ff.excl ? ent_ff.cnt == '0
                                                       : ent_ff.cnt == 6'd1)) begin
                     p_in = ent_ff.head;
                     n_in = '0;
                     state_in = S_WAKE;
                  end else begin
                     out_in.status = selt_pkg::StReleased;
                  end
               end else begin
                  out_in.status = selt_pkg::StNotHeld;
               end
            end
            if (state_in == S_WRITE) begin
               mem_we = 1'b1; mem_wd = ent_in;
               ovalid_in = 1'b1;
               state_in = S_RESP;
            end
         end
         S_WAKE: begin
            if (!ovalid_ff || rsp.ready) begin
               if (n_ff == '0) run_in = !wex_mem[p_ff];
               out_in = '{status: selt_pkg::StWoken, woken_proc: selt_pkg::ProcW'(p_ff),
                          last: 1'b0};
               ovalid_in = 1'b1;
               n_in = n_ff + 1'b1;
               next_valid_in[p_ff] = 1'b0;
               if (n_ff == '0 ? (!wex_mem[p_ff] && has_next && !nx_excl && NUM_PROCS > 1)
                              : more) begin
                  p_in = nx_p;
               end else begin
                  out_in.last = 1'b1;
                  if (has_next) ent_in.head = nx_p;
                  else ent_in.nonempty = 1'b0;
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            mem_we = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!ovalid_ff || rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         ovalid_ff <= 1'b0;
         next_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ovalid_ff <= ovalid_in;
         next_valid_ff <= next_valid_in;
      end
      lk_ff <= lk_in; rq_ff <= rq_in; cmd_ff <= cmd_in; ex_ff <= ex_in;
      ent_ff <= ent_in; p_ff <= p_in; n_ff <= n_in; run_ff <= run_in;
      out_ff <= out_in;
   end

   ap_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !ovalid_ff || rsp.ready || state_ff == S_IDLE)
      else $error("ready outside idle");
   ap_wake_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAKE && ovalid_ff) |-> out_ff.status == selt_pkg::StWoken)
      else $error("wake item with wrong status");
   ap_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("accept while busy");
endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// checks the lock table against its own predictor: a directed table of lock
// scenarios, a shared-count saturation burst, then random traffic, with
// random idling, a long response stall and a drain pause
// ---------------------------------------------------------------------------
module tb;
   typedef struct {
      selt_pkg::req_type item;
      bit                typed;
      selt_pkg::rsp_type want;
   } row_type;

   localparam int WatchLimit = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cyc = 0;
   int   quiet_cycles = 0;
   int   fail_count = 0;

   selt_req_if req ();
   selt_rsp_if rsp ();

   shared_exclusive_lock_table dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #4 clock = ~clock;

   // lock table as the block should hold it
   bit                          held_excl   [selt_pkg::NumLocksDef];
   logic [selt_pkg::CountW-1:0] holders     [selt_pkg::NumLocksDef];
   bit                          has_waiters [selt_pkg::NumLocksDef];
   logic [selt_pkg::ProcW-1:0]  wait_head   [selt_pkg::NumLocksDef];
   logic [selt_pkg::ProcW-1:0]  wait_tail   [selt_pkg::NumLocksDef];
   logic [selt_pkg::ProcW-1:0]  succ        [selt_pkg::NumProcsDef];
   bit                          succ_ok     [selt_pkg::NumProcsDef];
   bit                          waits_excl  [selt_pkg::NumProcsDef];

   selt_pkg::rsp_type expected_rsp [$];
   row_type plan [$];

   function automatic bit no_idle();
      return cyc >= 100 && cyc < 350;
   endfunction

   function automatic selt_pkg::rsp_type mk_rsp(logic [selt_pkg::StatusW-1:0] st,
                                                logic [selt_pkg::ProcW-1:0] p,
                                                logic lst);
      selt_pkg::rsp_type r;
      r.status = st;
      r.woken_proc = p;
      r.last = lst;
      return r;
   endfunction

   function automatic void add(logic c, int lk, int rq, logic ex, bit typed,
                               logic [selt_pkg::StatusW-1:0] st);
      row_type r;
      r.item.cmd = c;
      r.item.lock_id = lk[selt_pkg::LockW-1:0];
      r.item.requester = rq[selt_pkg::ProcW-1:0];
      r.item.want_exclusive = ex;
      r.typed = typed;
      r.want = mk_rsp(st, '0, 1'b1);
      plan.push_back(r);
   endfunction

   // works out the responses to one request and updates the table
   function automatic void predict_lock_op(selt_pkg::req_type r);
      int lk;
      int rq;
      int p;
      int nx;
      int n;
      bit shared_run;
      bit more;
      lk = r.lock_id;
      rq = r.requester;
      if (r.cmd == selt_pkg::CmdAcquire) begin
         if (r.want_exclusive && !held_excl[lk] && holders[lk] == 0) begin
            held_excl[lk] = 1'b1;
            expected_rsp.push_back(mk_rsp(selt_pkg::StGranted, '0, 1'b1));
            return;
         end
         if (!r.want_exclusive && !held_excl[lk]) begin
            if (holders[lk] < selt_pkg::SharedMax) holders[lk] = holders[lk] + 1'b1;
            expected_rsp.push_back(mk_rsp(selt_pkg::StGranted, '0, 1'b1));
            return;
         end
         waits_excl[rq] = r.want_exclusive;
         succ_ok[rq] = 1'b0;
         if (has_waiters[lk]) begin
            succ[wait_tail[lk]] = rq[selt_pkg::ProcW-1:0];
            succ_ok[wait_tail[lk]] = 1'b1;
         end else begin
            wait_head[lk] = rq[selt_pkg::ProcW-1:0];
            has_waiters[lk] = 1'b1;
         end
         wait_tail[lk] = rq[selt_pkg::ProcW-1:0];
         expected_rsp.push_back(mk_rsp(selt_pkg::StQueued, '0, 1'b1));
         return;
      end
      if (held_excl[lk]) begin
         held_excl[lk] = 1'b0;
      end else if (holders[lk] > 0) begin
         holders[lk] = holders[lk] - 1'b1;
      end else begin
         expected_rsp.push_back(mk_rsp(selt_pkg::StNotHeld, '0, 1'b1));
         return;
      end
      if (!has_waiters[lk] || held_excl[lk] || holders[lk] != 0) begin
         expected_rsp.push_back(mk_rsp(selt_pkg::StReleased, '0, 1'b1));
         return;
      end
      p = wait_head[lk];
      shared_run = !waits_excl[p];
      n = 0;
      forever begin
         nx = succ[p];
         n++;
         more = shared_run && succ_ok[p] && !waits_excl[nx] && n < selt_pkg::NumProcsDef;
         expected_rsp.push_back(mk_rsp(selt_pkg::StWoken, p[selt_pkg::ProcW-1:0], !more));
         if (!more) begin
            if (succ_ok[p]) wait_head[lk] = nx[selt_pkg::ProcW-1:0];
            else has_waiters[lk] = 1'b0;
            succ_ok[p] = 1'b0;
            break;
         end
         succ_ok[p] = 1'b0;
         p = nx;
      end
   endfunction

   task automatic send_req(selt_pkg::req_type item);
      while (!no_idle() && $urandom_range(0, 99) < 19) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= item;
      do @(posedge clock); while (!(req.valid && req.ready));
   endtask

   // response side: random stalls, one long hold-off, one stretch always ready
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) rsp.ready <= 1'b0;
      else if (cyc >= 400 && cyc < 650) rsp.ready <= 1'b0;
      else if (no_idle()) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 99) >= 19);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response item with nothing expected: %p", rsp.data);
            fail_count++;
         end else begin
            selt_pkg::rsp_type w;
            w = expected_rsp.pop_front();
            if (rsp.data.status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp.data.status);
               fail_count++;
            end
            if (rsp.data.woken_proc !== w.woken_proc) begin
               $error("woken_proc: expected %0d, got %0d", w.woken_proc,
                      rsp.data.woken_proc);
               fail_count++;
            end
            if (rsp.data.last !== w.last) begin
               $error("last: expected %0d, got %0d", w.last, rsp.data.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      selt_pkg::req_type item;
      int n0;
      req.valid = 1'b0;
      req.data = '0;
      for (int i = 0; i < selt_pkg::NumLocksDef; i++) begin
         held_excl[i] = 1'b0;
         holders[i] = '0;
         has_waiters[i] = 1'b0;
         wait_head[i] = '0;
         wait_tail[i] = '0;
      end
      for (int i = 0; i < selt_pkg::NumProcsDef; i++) begin
         succ[i] = '0;
         succ_ok[i] = 1'b0;
         waits_excl[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // release of a free lock, exclusive blocking a mixed queue
      add(selt_pkg::CmdRelease, 0, 0, 0, 1, selt_pkg::StNotHeld);
      add(selt_pkg::CmdAcquire, 63, 31, 1, 1, selt_pkg::StGranted);
      add(selt_pkg::CmdAcquire, 63, 0, 0, 1, selt_pkg::StQueued);
      add(selt_pkg::CmdAcquire, 63, 1, 0, 1, selt_pkg::StQueued);
      add(selt_pkg::CmdAcquire, 63, 2, 1, 1, selt_pkg::StQueued);
      add(selt_pkg::CmdRelease, 63, 0, 0, 0, selt_pkg::StWoken);
      add(selt_pkg::CmdRelease, 63, 0, 0, 1, selt_pkg::StNotHeld);
      add(selt_pkg::CmdAcquire, 63, 2, 1, 1, selt_pkg::StGranted);
      add(selt_pkg::CmdAcquire, 63, 3, 0, 1, selt_pkg::StQueued);
      add(selt_pkg::CmdRelease, 63, 0, 0, 0, selt_pkg::StWoken);
      add(selt_pkg::CmdRelease, 63, 0, 0, 1, selt_pkg::StNotHeld);
      // shared holders with an exclusive waiter
      add(selt_pkg::CmdAcquire, 0, 31, 0, 1, selt_pkg::StGranted);
      add(selt_pkg::CmdAcquire, 0, 30, 0, 1, selt_pkg::StGranted);
      add(selt_pkg::CmdAcquire, 0, 29, 1, 1, selt_pkg::StQueued);
      add(selt_pkg::CmdRelease, 0, 0, 0, 1, selt_pkg::StReleased);
      add(selt_pkg::CmdRelease, 0, 0, 0, 0, selt_pkg::StWoken);
      // same requester queued twice, one release wakes both of its entries
      add(selt_pkg::CmdAcquire, 3, 4, 1, 1, selt_pkg::StGranted);
      add(selt_pkg::CmdAcquire, 3, 5, 0, 1, selt_pkg::StQueued);
      add(selt_pkg::CmdAcquire, 3, 5, 0, 1, selt_pkg::StQueued);
      add(selt_pkg::CmdRelease, 3, 21, 1, 0, selt_pkg::StWoken);
      add(selt_pkg::CmdRelease, 3, 10, 1, 1, selt_pkg::StNotHeld);

      foreach (plan[i]) begin
         send_req(plan[i].item);
         n0 = expected_rsp.size();
         predict_lock_op(plan[i].item);
         if (plan[i].typed) expected_rsp[n0] = plan[i].want;
      end

      // shared count saturation on one lock
      for (int i = 0; i < 69; i++) begin
         item.cmd = (i >= 66) ? selt_pkg::CmdRelease : selt_pkg::CmdAcquire;
         item.lock_id = selt_pkg::LockW'(7);
         item.requester = selt_pkg::ProcW'($urandom_range(0, 31));
         item.want_exclusive = 1'b0;
         send_req(item);
         predict_lock_op(item);
      end

      for (int i = 0; i < 30; i++) begin
         if (i == 15) begin
            req.valid <= 1'b0;
            @(posedge clock);
            wait (expected_rsp.size() == 0);
            @(posedge clock);
         end
         item.cmd = ($urandom_range(0, 99) < 45) ? selt_pkg::CmdRelease
                                                 : selt_pkg::CmdAcquire;
         item.lock_id = ($urandom_range(0, 99) < 85)
                        ? selt_pkg::LockW'($urandom_range(0, 3))
                        : selt_pkg::LockW'($urandom_range(0, 63));
         item.requester = selt_pkg::ProcW'($urandom_range(0, 31));
         item.want_exclusive = 1'($urandom_range(0, 1));
         send_req(item);
         predict_lock_op(item);
      end
      req.valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[sim.f]
design/selt_pkg.sv
design/selt_req_if.sv
design/selt_rsp_if.sv
design/shared_exclusive_lock_table.sv
verif/tb.sv
